/* rtl/directional_spectrum_integrator_defines.svh */
// Assertion macros shared by the directional spectrum integrator RTL.
`ifndef DIRECTIONAL_SPECTRUM_INTEGRATOR_DEFINES_SVH
`define DIRECTIONAL_SPECTRUM_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsi_pkg.sv */
// Types, constants and helper functions of the directional spectrum integrator.
package dsi_pkg;

  localparam int DEF_MAX_DIRECTIONS = 64;
  localparam int DEF_ANGLE_BITS     = 16;
  localparam int SUM_W              = 48;
  localparam logic [6:0] DIR_COUNT_RESET = 7'd32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic signed [32:0] POLY_A   = 33'sd1324675879;
  localparam logic signed [32:0] POLY_B   = 33'sd272375560;
  localparam logic signed [32:0] POLY_C   = 33'sd22401992;
  localparam logic signed [32:0] POLY_D   = 33'sd987048;
  localparam logic signed [32:0] INV_K    = 33'sd27342611;
  localparam logic signed [25:0] HALF_W   = 26'sd1638400;
  localparam logic signed [39:0] Q30_ONE  = 40'sd1073741824;

  typedef struct packed {
    logic [15:0] density_value;
    logic [6:0]  first_spread;
    logic [6:0]  second_spread;
    logic [15:0] first_direction;
    logic [15:0] second_direction;
    logic        last_bin;
  } dsi_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] total_energy;
    logic             sum_saturated;
  } dsi_out_t;

  // Turns the last polynomial product into a signed Q15 cosine for its quadrant.
  function automatic logic signed [16:0] cos_finish(logic signed [65:0] prod,
                                                    logic [1:0] quad);
    logic signed [39:0] p;
    logic signed [16:0] m;
    p = Q30_ONE - 40'(prod >>> 30);
    if (p < 0) begin
      p = '0;
    end
    if (p > Q30_ONE) begin
      p = Q30_ONE;
    end
    m = 17'(p >>> 15);
    return (quad[0] ^ quad[1]) ? -m : m;
  endfunction

endpackage

/* rtl/dsi_div.sv */
// Bit-serial restoring divider that splits one full turn by the direction count.
module dsi_div #(
  parameter int ANGLE_BITS = 16,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CNT_W-1:0]      divisor,
  output logic                  done,
  output logic [ANGLE_BITS:0]   quot,
  output logic [CNT_W-1:0]      rem
);
  import dsi_pkg::*;

  localparam int IDX_W = $clog2(ANGLE_BITS + 1);

  logic              run_r;
  logic              done_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  rem_r;
  logic [ANGLE_BITS:0] quot_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W:0]    shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_r, (idx_r == IDX_W'(ANGLE_BITS))};
    fits    = (shifted >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        idx_r  <= IDX_W'(ANGLE_BITS);
        rem_r  <= '0;
        quot_r <= '0;
        div_r  <= divisor;
      end else if (run_r) begin
        rem_r  <= fits ? CNT_W'(shifted - {1'b0, div_r}) : CNT_W'(shifted);
        quot_r <= {quot_r[ANGLE_BITS-1:0], fits};
        if (idx_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

/* rtl/directional_spectrum_integrator.sv */
// Top level of the directional spectrum integrator.
//
// Each accepted beat is one frequency bin. The block first divides a full turn by the
// direction count in a bit-serial divider, then visits the directions one after
// another with one shared 33 x 33 multiplier: two cosine polynomials of five products
// each, two spread products, the scaling product and the density product, then the
// add into the bin total. The bin is then folded into the saturating running sum, and
// in_stall stays high from the taken beat until that fold, so a new beat is taken
// only after the current bin is done. A bin marked last also waits in its finish state
// while an earlier result beat is still stalled. The bin marked last emits the sum and
// its clip flag and clears both.
module directional_spectrum_integrator #(
  parameter int MAX_DIRECTIONS = dsi_pkg::DEF_MAX_DIRECTIONS,
  parameter int ANGLE_BITS     = dsi_pkg::DEF_ANGLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsi_pkg::dsi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dsi_pkg::dsi_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);
  import dsi_pkg::*;

  `include "directional_spectrum_integrator_defines.svh"

  localparam int N_W   = $clog2(MAX_DIRECTIONS + 1);
  localparam int BIN_W = 34 + $clog2(MAX_DIRECTIONS);
  localparam int ACC_W = ((BIN_W > SUM_W) ? BIN_W : SUM_W) + 2;
  localparam int AB    = ANGLE_BITS;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DIR, S_FIN} state_t;
  typedef enum logic [3:0] {
    ST_T2A, ST_DA, ST_CA, ST_BA, ST_AA,
    ST_T2B, ST_DB, ST_CB, ST_BB, ST_AB,
    ST_R1, ST_R2, ST_MAG, ST_DEN, ST_ACC
  } step_t;

  state_t               state_r;
  step_t                step_r;
  logic [6:0]           cfg_r;
  dsi_in_t              in_r;
  logic [N_W-1:0]       n_r;
  logic [N_W-1:0]       n_eff;
  logic [N_W-1:0]       j_r;
  logic [AB-1:0]        a_r;
  logic [N_W-1:0]       rem_r;
  logic [AB:0]          q0_r;
  logic [N_W-1:0]       r0_r;
  logic signed [65:0]   prod_r;
  logic signed [32:0]   t2_r;
  logic signed [16:0]   c1_r;
  logic signed [16:0]   c2_r;
  logic signed [25:0]   w_r;
  logic                 neg_r;
  logic signed [BIN_W-1:0] bin_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 ovf_r;
  logic                 out_valid_r;
  dsi_out_t             out_r;

  logic                 div_done;
  logic [AB:0]          div_quot;
  logic [N_W-1:0]       div_rem;
  logic                 in_accept;
  logic                 fin_go;

  logic [AB-1:0]        u1;
  logic [AB-1:0]        u2;
  logic [AB-1:0]        u_sel;
  logic [1:0]           quad1;
  logic [1:0]           quad2;
  logic [29:0]          t30;
  logic [30:0]          t31;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   prod;
  logic signed [32:0]   t2_now;
  logic signed [32:0]   h_now;
  logic signed [25:0]   w_full;
  logic [N_W:0]         rem_sum;
  logic                 rem_wrap;
  logic [AB-1:0]        a_nxt;
  logic [N_W-1:0]       rem_nxt;
  logic signed [BIN_W-1:0] term;
  logic signed [ACC_W-1:0] s_sum;

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = N_W'(1);
    end else if (32'(cfg_r) > MAX_DIRECTIONS) begin
      n_eff = N_W'(MAX_DIRECTIONS);
    end else begin
      n_eff = N_W'(cfg_r);
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign fin_go    = (state_r == S_FIN) && !(in_r.last_bin && out_valid_r && out_stall);

  dsi_div #(
    .ANGLE_BITS(ANGLE_BITS),
    .CNT_W     (N_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .divisor(n_eff),
    .done   (div_done),
    .quot   (div_quot),
    .rem    (div_rem)
  );

  always_comb begin
    u1    = a_r - AB'(in_r.first_direction);
    u2    = AB'((a_r - AB'(in_r.second_direction)) << 1);
    quad1 = u1[AB-1:AB-2];
    quad2 = u2[AB-1:AB-2];
    u_sel = (step_r == ST_T2A) ? u1 : u2;
    t30   = {u_sel[AB-3:0], {(32 - AB){1'b0}}};
    t31   = u_sel[AB-2] ? (31'(Q30_ONE) - {1'b0, t30}) : {1'b0, t30};
    t2_now = 33'(prod_r >>> 30);
    w_full = w_r + 26'(prod_r);

    unique case (step_r)
      ST_CA, ST_CB: h_now = POLY_C - t2_now;
      ST_BA, ST_BB: h_now = POLY_B - t2_now;
      default:      h_now = POLY_A - t2_now;
    endcase

    unique case (step_r)
      ST_T2A, ST_T2B: begin
        mul_a = $signed({2'b00, t31});
        mul_b = $signed({2'b00, t31});
      end
      ST_DA, ST_DB: begin
        mul_a = t2_now;
        mul_b = POLY_D;
      end
      ST_CA, ST_BA, ST_AA, ST_CB, ST_BB, ST_AB: begin
        mul_a = t2_r;
        mul_b = h_now;
      end
      ST_R1: begin
        mul_a = $signed({26'd0, in_r.first_spread});
        mul_b = 33'(c1_r);
      end
      ST_R2: begin
        mul_a = $signed({26'd0, in_r.second_spread});
        mul_b = 33'(c2_r);
      end
      ST_MAG: begin
        mul_a = (w_full < 0) ? 33'(-w_full) : 33'(w_full);
        mul_b = INV_K;
      end
      ST_DEN: begin
        mul_a = $signed({17'd0, in_r.density_value});
        mul_b = 33'(prod_r >>> 16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;

    rem_sum  = {1'b0, rem_r} + {1'b0, r0_r};
    rem_wrap = (rem_sum >= {1'b0, n_r});
    rem_nxt  = rem_wrap ? N_W'(rem_sum - {1'b0, n_r}) : N_W'(rem_sum);
    a_nxt    = a_r + q0_r[AB-1:0] + AB'(rem_wrap);

    term  = $signed({{(BIN_W - 33){1'b0}}, 33'(prod_r >>> 16)});
    s_sum = $signed({{(ACC_W - SUM_W){1'b0}}, sum_r}) + ACC_W'(bin_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_T2A;
      cfg_r       <= DIR_COUNT_RESET;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (fin_go && in_r.last_bin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= prod;
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            in_r    <= in_data;
            n_r     <= n_eff;
            bin_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q0_r    <= div_quot;
            r0_r    <= div_rem;
            a_r     <= '0;
            rem_r   <= '0;
            j_r     <= '0;
            step_r  <= ST_T2A;
            state_r <= S_DIR;
          end
        end
        S_DIR: begin
          step_r <= step_t'(step_r + 4'd1);
          unique case (step_r)
            ST_DA, ST_DB: t2_r <= t2_now;
            ST_T2B:       c1_r <= cos_finish(prod_r, quad1);
            ST_R1:        c2_r <= cos_finish(prod_r, quad2);
            ST_R2:        w_r  <= HALF_W + 26'(prod_r);
            ST_MAG:       neg_r <= (w_full < 0);
            ST_ACC: begin
              bin_r  <= neg_r ? (bin_r - term) : (bin_r + term);
              a_r    <= a_nxt;
              rem_r  <= rem_nxt;
              j_r    <= j_r + 1'b1;
              step_r <= ST_T2A;
              if (j_r == n_r - 1'b1) begin
                state_r <= S_FIN;
              end
            end
            default: begin
            end
          endcase
        end
        S_FIN: begin
          if (fin_go) begin
            state_r <= S_IDLE;
            if (in_r.last_bin) begin
              sum_r <= '0;
              ovf_r <= 1'b0;
              if (s_sum < 0) begin
                out_r.total_energy  <= '0;
                out_r.sum_saturated <= ovf_r;
              end else if (s_sum > $signed({{(ACC_W - SUM_W){1'b0}}, SUM_MAX})) begin
                out_r.total_energy  <= SUM_MAX;
                out_r.sum_saturated <= 1'b1;
              end else begin
                out_r.total_energy  <= SUM_W'(s_sum);
                out_r.sum_saturated <= ovf_r;
              end
            end else begin
              priority if (s_sum < 0) begin
                sum_r <= '0;
              end else if (s_sum > $signed({{(ACC_W - SUM_W){1'b0}}, SUM_MAX})) begin
                sum_r <= SUM_MAX;
                ovf_r <= 1'b1;
              end else begin
                sum_r <= SUM_W'(s_sum);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DSI_ASSERT_IMP(a_dir_in_range, state_r == S_DIR, j_r < n_r,
                  "direction index past the direction count")
  `DSI_ASSERT_IMP(a_rem_in_range, state_r == S_DIR, rem_r < n_r,
                  "angle step remainder not below the direction count")
  `DSI_ASSERT_NXT(a_out_held, out_valid_r && out_stall, out_valid_r && $stable(out_r),
                  "stalled result beat changed or dropped")
  `DSI_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN,
                  "result beat raised outside the bin finish")
  `DSI_ASSERT_NXT(a_last_dir_ends, (state_r == S_DIR) && (step_r == ST_ACC) &&
                  (j_r == n_r - 1'b1), state_r == S_FIN, "direction loop did not end")

endmodule
